@@ rtl/mark_sweep_collector_core_assert.svh @@
// Assertion macros shared by the collector RTL.
`ifndef MARK_SWEEP_COLLECTOR_CORE_ASSERT_SVH
`define MARK_SWEEP_COLLECTOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MSC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("collector check failed: same-cycle implication");
`define MSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("collector check failed: next-cycle implication");
`else
`define MSC_ASSERT_IMPLY(label, ante, cons)
`define MSC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/msc_pkg.sv @@
// Shared constants, codes and types of the mark-sweep collector.
package msc_pkg;

   localparam int NUM_OBJECTS  = 32;
   localparam int MAX_CHILDREN = 8;

   localparam int OBJ_W      = $clog2(NUM_OBJECTS);
   localparam int SLOT_W     = $clog2(MAX_CHILDREN);
   localparam int CNT_W      = $clog2(MAX_CHILDREN + 1);
   localparam int REF_W      = $clog2(NUM_OBJECTS + 1);
   localparam int KIND_W     = 3;
   localparam int STATUS_W   = 3;
   localparam int SURV_W     = $clog2(NUM_OBJECTS + 1);
   localparam int OP_W       = 2;
   localparam int META_W     = KIND_W + CNT_W;
   localparam int REF_ADDR_W = OBJ_W + SLOT_W;
   localparam int REF_DEPTH  = NUM_OBJECTS * MAX_CHILDREN;

   localparam logic [KIND_W-1:0] KIND_VECTOR3 = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ARRAY   = 3'd4;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE  = 2'd0,
      OP_SET     = 2'd1,
      OP_ROOT    = 2'd2,
      OP_COLLECT = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_IN_USE     = 3'd1,
      STAT_NOT_LIVE   = 3'd2,
      STAT_BAD_CHILD  = 3'd3,
      STAT_BAD_TARGET = 3'd4
   } status_type;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_CLEAR  = 11'b00000000010,
      S_SET_RD = 11'b00000000100,
      S_EMIT   = 11'b00000001000,
      S_C_PUSH = 11'b00000010000,
      S_C_POP  = 11'b00000100000,
      S_C_META = 11'b00001000000,
      S_C_REF  = 11'b00010000000,
      S_SWEEP  = 11'b00100000000,
      S_FINAL  = 11'b01000000000,
      S_SPARE  = 11'b10000000000
   } state_type;

endpackage

@@ rtl/mark_sweep_collector_core.sv @@
// Mark-sweep collector: object table, tracer and sweeper over slot memories.
//
// Request channel (req_*): one word per op; req_tuser carries the op code,
// req_tdata the object fields. A word is taken only while the core is idle.
// Response channel (rsp_*): create, set and root give one word with tlast
// high; create first clears the child row one entry a cycle. Collect gives
// one word per freed slot (tuser high, tlast low) and a final word with the
// survivor count and tlast high. Collect scans every slot for roots, then
// traces each reached object and its child references, where the single
// read port of the reference memory sets the pace, then sweeps every slot.
// Responses sit in one output register; while the receiver stalls the
// sequencer holds at its next response and resumes when the word is taken.
// Reset (synchronous, active high) clears the live, mark and root flags,
// the gray stack pointer and the sequencer; the kind, count and reference
// memories are not cleared, a create writes them before any read.
module mark_sweep_collector_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] obj_index, [7:5] obj_kind, [11:8] array_size, [14:12] child_slot,
   // [19:15] target_index, [20] target_present, [23:21] zero
   input  logic [23:0] req_tdata,
   // [1:0] op
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [7:3] freed_index, [13:8] survivors, [15:14] zero
   output logic [15:0] rsp_tdata,
   // [0] freed_valid
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   localparam int OBJ_W  = msc_pkg::OBJ_W;
   localparam int SLOT_W = msc_pkg::SLOT_W;
   localparam int CNT_W  = msc_pkg::CNT_W;
   localparam int REF_W  = msc_pkg::REF_W;
   localparam int KIND_W = msc_pkg::KIND_W;
   localparam int SURV_W = msc_pkg::SURV_W;
   localparam int NOBJ   = msc_pkg::NUM_OBJECTS;

   // request fields
   logic [OBJ_W-1:0]  req_idx;
   logic [KIND_W-1:0] req_kind;
   logic [3:0]        req_asize;
   logic [SLOT_W-1:0] req_cslot;
   logic [OBJ_W-1:0]  req_tgt;
   logic              req_tpres;
   logic              req_accept;

   assign req_idx    = req_tdata[4:0];
   assign req_kind   = req_tdata[7:5];
   assign req_asize  = req_tdata[11:8];
   assign req_cslot  = req_tdata[14:12];
   assign req_tgt    = req_tdata[19:15];
   assign req_tpres  = req_tdata[20];
   assign req_accept = req_tvalid && req_tready;

   // control and flag registers
   msc_pkg::state_type  state_ff, state_in;
   msc_pkg::status_type status_ff, status_in;
   logic [NOBJ-1:0]   live_ff, live_in;
   logic [NOBJ-1:0]   mark_ff, mark_in;
   logic [NOBJ-1:0]   root_ff, root_in;
   logic [OBJ_W:0]    top_ff, top_in;
   logic [OBJ_W-1:0]  ptr_ff, ptr_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]  nch_ff, nch_in;
   logic [OBJ_W-1:0]  cur_ff, cur_in;
   logic [SURV_W-1:0] surv_ff, surv_in;
   logic [OBJ_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0] cslot_ff, cslot_in;
   logic [OBJ_W-1:0]  tgt_ff, tgt_in;
   logic              tpres_ff, tpres_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   msc_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic                  rsp_fv_ff, rsp_fv_in;
   logic [OBJ_W-1:0]      rsp_fi_ff, rsp_fi_in;
   logic [SURV_W-1:0]     rsp_surv_ff, rsp_surv_in;
   logic                  rsp_last_ff, rsp_last_in;

   // gray stack
   logic [OBJ_W-1:0] stack_ff [NOBJ];
   logic             push_en;
   logic [OBJ_W-1:0] push_data;
   logic [OBJ_W-1:0] stack_top;

   // memories
   logic                         meta_we;
   logic [OBJ_W-1:0]             meta_waddr;
   logic [msc_pkg::META_W-1:0]   meta_wdata;
   logic [OBJ_W-1:0]             meta_raddr;
   logic [msc_pkg::META_W-1:0]   meta_rdata;
   logic                         ref_we;
   logic [msc_pkg::REF_ADDR_W-1:0] ref_waddr;
   logic [REF_W-1:0]             ref_wdata;
   logic [msc_pkg::REF_ADDR_W-1:0] ref_raddr;
   logic [REF_W-1:0]             ref_rdata;

   // decoded values
   logic              out_free;
   logic [CNT_W-1:0]  create_nch;
   logic [KIND_W-1:0] rd_kind;
   logic [CNT_W-1:0]  rd_count;
   logic [OBJ_W-1:0]  ref_target;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stack_top  = stack_ff[OBJ_W'(top_ff - 1'b1)];
   assign rd_kind    = meta_rdata[msc_pkg::META_W-1:CNT_W];
   assign rd_count   = meta_rdata[CNT_W-1:0];
   assign ref_target = OBJ_W'(ref_rdata - 1'b1);
   assign meta_raddr = (state_ff == msc_pkg::S_IDLE) ? req_idx : stack_top;
   assign ref_raddr  = (state_ff == msc_pkg::S_C_META) ? {cur_ff, SLOT_W'(0)}
                                                       : {cur_ff, SLOT_W'(cnt_ff + 1'b1)};

   // child count of a new object
   always_comb begin
      if (req_kind == msc_pkg::KIND_VECTOR3) begin
         create_nch = CNT_W'(3);
      end else if (req_kind == msc_pkg::KIND_ARRAY) begin
         create_nch = (CNT_W'(req_asize) > CNT_W'(msc_pkg::MAX_CHILDREN))
                      ? CNT_W'(msc_pkg::MAX_CHILDREN) : CNT_W'(req_asize);
      end else begin
         create_nch = '0;
      end
   end

   msc_ram #(.WIDTH(msc_pkg::META_W), .DEPTH(NOBJ)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   msc_ram #(.WIDTH(REF_W), .DEPTH(msc_pkg::REF_DEPTH)) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_waddr),
      .wr_data (ref_wdata),
      .rd_addr (ref_raddr),
      .rd_data (ref_rdata)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      live_in    = live_ff;
      mark_in    = mark_ff;
      root_in    = root_ff;
      top_in     = top_ff;
      ptr_in     = ptr_ff;
      cnt_in     = cnt_ff;
      nch_in     = nch_ff;
      cur_in     = cur_ff;
      surv_in    = surv_ff;
      idx_in     = idx_ff;
      cslot_in   = cslot_ff;
      tgt_in     = tgt_ff;
      tpres_in   = tpres_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_fv_in     = rsp_fv_ff;
      rsp_fi_in     = rsp_fi_ff;
      rsp_surv_in   = rsp_surv_ff;
      rsp_last_in   = rsp_last_ff;
      push_en    = 1'b0;
      push_data  = ptr_ff;
      meta_we    = 1'b0;
      meta_waddr = req_idx;
      meta_wdata = {req_kind, create_nch};
      ref_we     = 1'b0;
      ref_waddr  = {idx_ff, cnt_ff};
      ref_wdata  = '0;

      unique case (state_ff)
         msc_pkg::S_IDLE: begin
            if (req_accept) begin
               idx_in   = req_idx;
               cslot_in = req_cslot;
               tgt_in   = req_tgt;
               tpres_in = req_tpres;
               unique case (msc_pkg::op_type'(req_tuser))
                  msc_pkg::OP_CREATE: begin
                     if (live_ff[req_idx]) begin
                        status_in = msc_pkg::STAT_IN_USE;
                        state_in  = msc_pkg::S_EMIT;
                     end else begin
                        live_in[req_idx] = 1'b1;
                        mark_in[req_idx] = 1'b0;
                        root_in[req_idx] = 1'b0;
                        meta_we  = 1'b1;
                        cnt_in   = '0;
                        state_in = msc_pkg::S_CLEAR;
                     end
                  end
                  msc_pkg::OP_SET: begin
                     state_in = msc_pkg::S_SET_RD;
                  end
                  msc_pkg::OP_ROOT: begin
                     if (live_ff[req_idx]) begin
                        root_in[req_idx] = 1'b1;
                        status_in = msc_pkg::STAT_OK;
                     end else begin
                        status_in = msc_pkg::STAT_NOT_LIVE;
                     end
                     state_in = msc_pkg::S_EMIT;
                  end
                  msc_pkg::OP_COLLECT: begin
                     mark_in  = mark_ff | (live_ff & root_ff);
                     ptr_in   = '0;
                     top_in   = '0;
                     state_in = msc_pkg::S_C_PUSH;
                  end
                  default: ;
               endcase
            end
         end

         // null every child reference of a new object
         msc_pkg::S_CLEAR: begin
            ref_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SLOT_W'(msc_pkg::MAX_CHILDREN - 1)) begin
               status_in = msc_pkg::STAT_OK;
               state_in  = msc_pkg::S_EMIT;
            end
         end

         // child count is back from the meta RAM
         msc_pkg::S_SET_RD: begin
            if (!live_ff[idx_ff]) begin
               status_in = msc_pkg::STAT_NOT_LIVE;
            end else if (CNT_W'(cslot_ff) >= rd_count) begin
               status_in = msc_pkg::STAT_BAD_CHILD;
            end else if (tpres_ff && !live_ff[tgt_ff]) begin
               status_in = msc_pkg::STAT_BAD_TARGET;
            end else begin
               status_in = msc_pkg::STAT_OK;
               ref_we    = 1'b1;
               ref_waddr = {idx_ff, cslot_ff};
               ref_wdata = tpres_ff ? (REF_W'(tgt_ff) + 1'b1) : '0;
            end
            state_in = msc_pkg::S_EMIT;
         end

         msc_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_fv_in     = 1'b0;
               rsp_fi_in     = '0;
               rsp_surv_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = msc_pkg::S_IDLE;
            end
         end

         // push every marked root in ascending slot order
         msc_pkg::S_C_PUSH: begin
            if (live_ff[ptr_ff] && mark_ff[ptr_ff]) begin
               push_en   = 1'b1;
               push_data = ptr_ff;
               top_in    = top_ff + 1'b1;
            end
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == OBJ_W'(NOBJ - 1)) begin
               state_in = msc_pkg::S_C_POP;
            end
         end

         // pop one gray object, its meta read is issued here
         msc_pkg::S_C_POP: begin
            if (top_ff == '0) begin
               ptr_in   = '0;
               surv_in  = '0;
               state_in = msc_pkg::S_SWEEP;
            end else begin
               top_in   = top_ff - 1'b1;
               cur_in   = stack_top;
               state_in = msc_pkg::S_C_META;
            end
         end

         // only vector3 and array objects have children to trace
         msc_pkg::S_C_META: begin
            if ((rd_kind == msc_pkg::KIND_VECTOR3 || rd_kind == msc_pkg::KIND_ARRAY)
                && rd_count != '0) begin
               nch_in   = rd_count;
               cnt_in   = '0;
               state_in = msc_pkg::S_C_REF;
            end else begin
               state_in = msc_pkg::S_C_POP;
            end
         end

         // one child reference a cycle, next read already in flight
         msc_pkg::S_C_REF: begin
            if (ref_rdata != '0 && live_ff[ref_target] && !mark_ff[ref_target]) begin
               mark_in[ref_target] = 1'b1;
               push_en   = 1'b1;
               push_data = ref_target;
               top_in    = top_ff + 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (CNT_W'(cnt_ff) + 1'b1 >= nch_ff) begin
               state_in = msc_pkg::S_C_POP;
            end
         end

         // free unmarked live slots, clear marks of survivors
         msc_pkg::S_SWEEP: begin
            if (!live_ff[ptr_ff] || mark_ff[ptr_ff] || out_free) begin
               if (live_ff[ptr_ff]) begin
                  if (mark_ff[ptr_ff]) begin
                     mark_in[ptr_ff] = 1'b0;
                     surv_in = surv_ff + 1'b1;
                  end else begin
                     live_in[ptr_ff] = 1'b0;
                     root_in[ptr_ff] = 1'b0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = msc_pkg::STAT_OK;
                     rsp_fv_in     = 1'b1;
                     rsp_fi_in     = ptr_ff;
                     rsp_surv_in   = '0;
                     rsp_last_in   = 1'b0;
                  end
               end
               ptr_in = ptr_ff + 1'b1;
               if (ptr_ff == OBJ_W'(NOBJ - 1)) begin
                  state_in = msc_pkg::S_FINAL;
               end
            end
         end

         msc_pkg::S_FINAL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = msc_pkg::STAT_OK;
               rsp_fv_in     = 1'b0;
               rsp_fi_in     = '0;
               rsp_surv_in   = surv_ff;
               rsp_last_in   = 1'b1;
               state_in      = msc_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = msc_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msc_pkg::S_IDLE;
         live_ff      <= '0;
         mark_ff      <= '0;
         root_ff      <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         mark_ff      <= mark_in;
         root_ff      <= root_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      ptr_ff        <= ptr_in;
      cnt_ff        <= cnt_in;
      nch_ff        <= nch_in;
      cur_ff        <= cur_in;
      surv_ff       <= surv_in;
      idx_ff        <= idx_in;
      cslot_ff      <= cslot_in;
      tgt_ff        <= tgt_in;
      tpres_ff      <= tpres_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fv_ff     <= rsp_fv_in;
      rsp_fi_ff     <= rsp_fi_in;
      rsp_surv_ff   <= rsp_surv_in;
      rsp_last_ff   <= rsp_last_in;
      if (push_en) begin
         stack_ff[top_ff[OBJ_W-1:0]] <= push_data;
      end
   end

   assign req_tready = (state_ff == msc_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_surv_ff, rsp_fi_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_fv_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `include "mark_sweep_collector_core_assert.svh"

   `MSC_ASSERT_IMPLY(a_freed_not_last, rsp_valid_ff && rsp_fv_ff, !rsp_last_ff)
   `MSC_ASSERT_IMPLY(a_idle_stack_empty, state_ff == msc_pkg::S_IDLE, top_ff == '0)
   `MSC_ASSERT_NEXT(a_accept_leaves_idle, req_accept, state_ff != msc_pkg::S_IDLE)

endmodule

@@ rtl/msc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module msc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
